/* rtl/t3ped_pkg.sv */
// shared types and constants of the t3 photon event decoder
package t3ped_pkg;

   localparam int TIME_WIDTH_DEFAULT = 48;
   localparam int MARKER_SLOTS       = 16;
   localparam int SLOT_BITS          = $clog2(MARKER_SLOTS);
   localparam int WRAP_SHIFT         = 10;
   localparam int REPEAT_GAP         = 5;
   localparam int INDEX_WIDTH        = 48;
   localparam int COUNT_WIDTH        = 32;
   localparam int SUM_WIDTH          = 48;
   localparam int REPORTED_WIDTH     = 16;
   localparam int DELAY_WIDTH        = 15;
   localparam int CHANNEL_WIDTH      = 6;
   localparam int SYNC_WIDTH         = 10;
   localparam int OUT_TIME_WIDTH     = 48;
   localparam int RSP_DATA_WIDTH     = 200;
   localparam int CSR_ADDR_WIDTH     = 5;
   localparam int CSR_DATA_WIDTH     = 32;

   localparam logic [CHANNEL_WIDTH-1:0] OVF_CHANNEL    = 6'h3F;
   localparam logic [CHANNEL_WIDTH-1:0] LAST_MARKER_CH = 6'd15;

   typedef enum logic [1:0] {
      KIND_MARKER   = 2'd0,
      KIND_PHOTON   = 2'd1,
      KIND_OVERFLOW = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      REG_EMIT_OVERFLOWS = 3'd0,
      REG_EMIT_MARKERS   = 3'd1,
      REG_EMIT_EARLY     = 3'd2,
      REG_PHOTON_LIMIT   = 3'd3,
      REG_GATE_MIN       = 3'd4,
      REG_GATE_MAX       = 3'd5
   } reg_addr_type;

   typedef struct packed {
      logic        emit_overflows;
      logic        emit_markers;
      logic        emit_early;
      logic [16:0] photon_limit;
      logic [15:0] gate_min;
      logic [15:0] gate_max;
   } cfg_type;

endpackage

/* rtl/t3ped_ram.sv */
// generic single write port ram with registered read
module t3ped_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/t3ped_csr.sv */
// configuration registers behind the apb-style port
module t3ped_csr
   import t3ped_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   logic         wr_en;
   reg_addr_type addr;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign addr       = reg_addr_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (addr)
            REG_EMIT_OVERFLOWS: cfg_in.emit_overflows = csr_pwdata[0];
            REG_EMIT_MARKERS:   cfg_in.emit_markers   = csr_pwdata[0];
            REG_EMIT_EARLY:     cfg_in.emit_early     = csr_pwdata[0];
            REG_PHOTON_LIMIT:   cfg_in.photon_limit   = csr_pwdata[16:0];
            REG_GATE_MIN:       cfg_in.gate_min       = csr_pwdata[15:0];
            REG_GATE_MAX:       cfg_in.gate_max       = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (addr)
         REG_EMIT_OVERFLOWS: csr_prdata = {31'd0, cfg_ff.emit_overflows};
         REG_EMIT_MARKERS:   csr_prdata = {31'd0, cfg_ff.emit_markers};
         REG_EMIT_EARLY:     csr_prdata = {31'd0, cfg_ff.emit_early};
         REG_PHOTON_LIMIT:   csr_prdata = {{15{cfg_ff.photon_limit[16]}}, cfg_ff.photon_limit};
         REG_GATE_MIN:       csr_prdata = {{16{cfg_ff.gate_min[15]}}, cfg_ff.gate_min};
         REG_GATE_MAX:       csr_prdata = {{16{cfg_ff.gate_max[15]}}, cfg_ff.gate_max};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.emit_overflows <= 1'b0;
         cfg_ff.emit_markers   <= 1'b1;
         cfg_ff.emit_early     <= 1'b0;
         cfg_ff.photon_limit   <= '1;
         cfg_ff.gate_min       <= '1;
         cfg_ff.gate_max       <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/t3_photon_event_decoder_unit.sv */
// t3 time-tag record decoder: top level
//
// req_* carries one 32-bit t3 record per transaction. rsp_* carries at most one
// report per record: tuser holds the report kind, tdata the report fields.
// csr_* is an apb-style port with six registers at byte addresses 0 to 20;
// writes are to be made only while the block is idle; the block does not enforce it.
// the marker time memory is read at the edge that accepts a record, together with
// the decode stage register; the output register loads when the decode stage
// fires, and the report is then held on rsp_* until it is taken.
// throughput: one record per cycle unless the receiver stalls, set by the
// read-modify-write of the marker time memory, with the last write forwarded to
// the next read. records that cause no report are retired in the same pipeline slot.
// reset clears the offset, the window totals, the record counter and the
// per-channel valid bits of the marker memory; the registers take their
// defaults. no clearing pass is needed.
// when the receiver stalls, the output register holds the report, the decode
// stage holds the next record, and req_tready drops once both are full.
module t3_photon_event_decoder_unit
   import t3ped_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,   // record_word
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // record_index, channel, sync_time, delay_bin, window_photons,
   // window_delay_total, zero pad
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic [1:0]                rsp_tuser,   // kind
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type cfg;

   t3ped_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // decode stage
   logic                      s1_valid_ff;
   logic [31:0]               s1_word_ff;
   logic                      s1_fire;
   logic                      out_free;
   logic                      req_accept;

   // state
   logic [TIME_WIDTH-1:0]     offset_ff;
   logic [MARKER_SLOTS-1:0]   slot_valid_ff;
   logic                      fwd_valid_ff;
   logic [SLOT_BITS-1:0]      fwd_slot_ff;
   logic [TIME_WIDTH-1:0]     fwd_data_ff;
   logic                      armed_ff;
   logic [REPORTED_WIDTH-1:0] reported_ff;
   logic [COUNT_WIDTH-1:0]    wcount_ff;
   logic [SUM_WIDTH-1:0]      wsum_ff;
   logic [INDEX_WIDTH-1:0]    rec_count_ff;

   // output register
   logic                      rsp_valid_ff;
   kind_type                  rsp_kind_ff;
   logic [INDEX_WIDTH-1:0]    rsp_index_ff;
   logic [CHANNEL_WIDTH-1:0]  rsp_channel_ff;
   logic [OUT_TIME_WIDTH-1:0] rsp_time_ff;
   logic [DELAY_WIDTH-1:0]    rsp_delay_ff;
   logic [COUNT_WIDTH-1:0]    rsp_wcount_ff;
   logic [SUM_WIDTH-1:0]      rsp_wsum_ff;

   // decode
   logic [SYNC_WIDTH-1:0]     nsync;
   logic [DELAY_WIDTH-1:0]    dly;
   logic [CHANNEL_WIDTH-1:0]  ch;
   logic                      special;
   logic [SLOT_BITS-1:0]      slot;
   logic                      is_ovf;
   logic                      is_marker;
   logic                      is_photon;
   logic [TIME_WIDTH-1:0]     t_now;
   logic [TIME_WIDTH-1:0]     ram_rdata;
   logic [TIME_WIDTH-1:0]     last_time;
   logic [TIME_WIDTH-1:0]     gap;
   logic                      marker_report;
   logic                      gate_pass;
   logic                      under_limit;
   logic                      photon_report;
   logic                      ovf_report;
   logic                      emit;
   logic [TIME_WIDTH-1:0]     ovf_step;
   logic [SUM_WIDTH:0]        wsum_grown;

   logic [TIME_WIDTH-1:0]     offset_in;
   logic                      armed_in;
   logic [REPORTED_WIDTH-1:0] reported_in;
   logic [COUNT_WIDTH-1:0]    wcount_in;
   logic [SUM_WIDTH-1:0]      wsum_in;
   kind_type                  kind_in;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_accept = req_tvalid && req_tready;

   t3ped_ram #(
      .WIDTH (TIME_WIDTH),
      .DEPTH (MARKER_SLOTS)
   ) u_marker_ram (
      .clock   (clock),
      .wr_en   (s1_fire && is_marker),
      .wr_addr (slot),
      .wr_data (t_now),
      .rd_en   (req_accept),
      .rd_addr (req_tdata[25 +: SLOT_BITS]),
      .rd_data (ram_rdata)
   );

   assign nsync   = s1_word_ff[9:0];
   assign dly     = s1_word_ff[24:10];
   assign ch      = s1_word_ff[30:25];
   assign special = s1_word_ff[31];
   assign slot    = ch[SLOT_BITS-1:0];

   assign is_ovf    = special && (ch == OVF_CHANNEL);
   assign is_marker = special && (ch != '0) && (ch <= LAST_MARKER_CH);
   assign is_photon = !special;

   assign t_now = offset_ff + TIME_WIDTH'(nsync);

   always_comb begin
      if (!slot_valid_ff[slot]) begin
         last_time = '0;
      end else if (fwd_valid_ff && (fwd_slot_ff == slot)) begin
         last_time = fwd_data_ff;
      end else begin
         last_time = ram_rdata;
      end
   end

   assign gap = t_now - last_time;
   assign marker_report = is_marker && cfg.emit_markers &&
                          ((last_time == '0) ||
                           ((t_now > last_time) && (gap > TIME_WIDTH'(REPEAT_GAP))));

   assign gate_pass = (cfg.gate_min[15] || (dly >= cfg.gate_min[14:0])) &&
                      (cfg.gate_max[15] || (dly <= cfg.gate_max[14:0]));
   assign under_limit = cfg.photon_limit[16] || (reported_ff < cfg.photon_limit[15:0]);
   assign photon_report = is_photon && (cfg.emit_early || armed_ff) && under_limit &&
                          gate_pass;
   assign ovf_report = is_ovf && cfg.emit_overflows;
   assign emit = ovf_report || marker_report || photon_report;

   assign ovf_step   = (nsync == '0) ? TIME_WIDTH'(1 << WRAP_SHIFT)
                                     : TIME_WIDTH'({nsync, {WRAP_SHIFT{1'b0}}});
   assign wsum_grown = {1'b0, wsum_ff} + (SUM_WIDTH + 1)'(dly);

   always_comb begin
      offset_in   = offset_ff;
      armed_in    = armed_ff;
      reported_in = reported_ff;
      wcount_in   = wcount_ff;
      wsum_in     = wsum_ff;
      if (is_ovf) begin
         offset_in = offset_ff + ovf_step;
      end
      if (marker_report) begin
         armed_in    = 1'b1;
         reported_in = '0;
         wcount_in   = '0;
         wsum_in     = '0;
      end
      if (photon_report && (reported_ff != '1)) begin
         reported_in = reported_ff + 1'b1;
      end
      if (is_photon && gate_pass) begin
         if (wcount_ff != '1) begin
            wcount_in = wcount_ff + 1'b1;
         end
         wsum_in = wsum_grown[SUM_WIDTH] ? '1 : wsum_grown[SUM_WIDTH-1:0];
      end
   end

   always_comb begin
      if (marker_report) begin
         kind_in = KIND_MARKER;
      end else if (photon_report) begin
         kind_in = KIND_PHOTON;
      end else begin
         kind_in = KIND_OVERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         offset_ff     <= '0;
         slot_valid_ff <= '0;
         fwd_valid_ff  <= 1'b0;
         armed_ff      <= 1'b0;
         reported_ff   <= '0;
         wcount_ff     <= '0;
         wsum_ff       <= '0;
         rec_count_ff  <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s1_fire && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            offset_ff    <= offset_in;
            armed_ff     <= armed_in;
            reported_ff  <= reported_in;
            wcount_ff    <= wcount_in;
            wsum_ff      <= wsum_in;
            rec_count_ff <= rec_count_ff + 1'b1;
            if (is_marker) begin
               slot_valid_ff[slot] <= 1'b1;
               fwd_valid_ff        <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_word_ff <= req_tdata;
      end
      if (s1_fire && is_marker) begin
         fwd_slot_ff <= slot;
         fwd_data_ff <= t_now;
      end
      if (s1_fire && emit) begin
         rsp_kind_ff    <= kind_in;
         rsp_index_ff   <= rec_count_ff;
         rsp_channel_ff <= is_ovf ? '0 : ch;
         rsp_time_ff    <= photon_report ? OUT_TIME_WIDTH'(t_now) : '0;
         rsp_delay_ff   <= photon_report ? dly : '0;
         rsp_wcount_ff  <= marker_report ? wcount_ff : '0;
         rsp_wsum_ff    <= marker_report ? wsum_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {3'b000, rsp_wsum_ff, rsp_wcount_ff, rsp_delay_ff, rsp_time_ff,
                        rsp_channel_ff, rsp_index_ff};

   // assertions
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_word_ff))
      else $error("decode stage lost a stalled record");

   a_arm_by_marker: assert property (@(posedge clock) disable iff (reset)
      $rose(armed_ff) |-> $past(s1_fire && marker_report))
      else $error("armed without a marker report");

   a_photon_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_PHOTON) |-> (rsp_wcount_ff == '0) &&
      (rsp_wsum_ff == '0))
      else $error("photon report carries window totals");

   a_fwd_matches_valid: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> slot_valid_ff[fwd_slot_ff])
      else $error("forwarded slot not marked valid");

endmodule

/* bench/testbench.sv */
// record streams driven into the t3 photon event decoder, reports checked against a predictor
`timescale 1ns / 100ps

module testbench;
   import t3ped_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;

   typedef struct packed {
      kind_type    kind;
      logic [47:0] index;
      logic [5:0]  channel;
      logic [47:0] sync_time;
      logic [14:0] delay_bin;
      logic [31:0] photons;
      logic [47:0] delay_total;
   } report_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [31:0]               req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [1:0]                rsp_tuser;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // predictor state and settings
   cfg_type       cfg = {1'b0, 1'b1, 1'b0, 17'h1FFFF, 16'hFFFF, 16'hFFFF};
   logic [47:0]   sync_offset = '0;
   logic [47:0]   marker_time [MARKER_SLOTS] = '{default: '0};
   logic          armed = 1'b0;
   logic [15:0]   photons_sent = '0;
   logic [31:0]   window_photons = '0;
   logic [47:0]   window_delay_sum = '0;
   logic [47:0]   record_count = '0;
   report_type    reports_due [$];
   report_type    want;

   int            mismatches = 0;
   int            hold_len = 0;
   bit            quiet = 1'b0;
   int unsigned   cycle_count = 0;

   t3_photon_event_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench NOT OK");
         $finish;
      end
   end

   function automatic void decode_record(input logic [31:0] word);
      logic [9:0]    nsync;
      logic [14:0]   dly;
      logic [5:0]    ch;
      logic [3:0]    slot;
      logic [47:0]   stamp;
      logic          gated;
      report_type    r;
      nsync = word[9:0];
      dly   = word[24:10];
      ch    = word[30:25];
      slot  = ch[3:0];
      r = '0;
      r.index   = record_count;
      r.channel = ch;
      if (word[31]) begin
         if (ch == OVF_CHANNEL) begin
            if (cfg.emit_overflows) begin
               r.kind    = KIND_OVERFLOW;
               r.channel = '0;
               reports_due.push_back(r);
            end
            sync_offset = sync_offset + ((nsync == 0 ? 48'd1 : 48'(nsync)) << WRAP_SHIFT);
         end else if (ch >= 1 && ch <= LAST_MARKER_CH) begin
            stamp = sync_offset + 48'(nsync);
            if (cfg.emit_markers && (marker_time[slot] == 0 ||
                (stamp > marker_time[slot] && stamp - marker_time[slot] > REPEAT_GAP))) begin
               r.kind        = KIND_MARKER;
               r.photons     = window_photons;
               r.delay_total = window_delay_sum;
               reports_due.push_back(r);
               window_photons   = '0;
               window_delay_sum = '0;
               photons_sent     = '0;
               armed            = 1'b1;
            end
            marker_time[slot] = stamp;
         end
      end else begin
         gated = (cfg.gate_min[15] || dly >= cfg.gate_min[14:0]) &&
                 (cfg.gate_max[15] || dly <= cfg.gate_max[14:0]);
         if ((cfg.emit_early || armed) && gated &&
             (cfg.photon_limit[16] || photons_sent < cfg.photon_limit[15:0])) begin
            r.kind      = KIND_PHOTON;
            r.sync_time = sync_offset + 48'(nsync);
            r.delay_bin = dly;
            reports_due.push_back(r);
            if (photons_sent != 16'hFFFF) photons_sent++;
         end
         if (gated) begin
            if (window_photons != 32'hFFFF_FFFF) window_photons++;
            window_delay_sum = (window_delay_sum > 48'hFFFF_FFFF_FFFF - 48'(dly)) ?
                               48'hFFFF_FFFF_FFFF : window_delay_sum + 48'(dly);
         end
      end
      record_count++;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] expected,
                                       input logic [63:0] actual);
      if (actual !== expected) begin
         mismatches++;
         if (mismatches <= 50)
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, name, expected, actual);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (reports_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 50)
               $display("%0t: unexpected transaction, expected none actual kind %0d data %0h",
                        $time, rsp_tuser, rsp_tdata);
         end else begin
            want = reports_due.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_tuser));
            check_field("record_index", 64'(want.index), 64'(rsp_tdata[47:0]));
            check_field("channel", 64'(want.channel), 64'(rsp_tdata[53:48]));
            check_field("sync_time", 64'(want.sync_time), 64'(rsp_tdata[101:54]));
            check_field("delay_bin", 64'(want.delay_bin), 64'(rsp_tdata[116:102]));
            check_field("window_photons", 64'(want.photons), 64'(rsp_tdata[148:117]));
            check_field("window_delay_total", 64'(want.delay_total),
                        64'(rsp_tdata[196:149]));
         end
      end
   end

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_len > 0) begin
         rsp_tready <= 1'b0;
         hold_len = hold_len - 1;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 32);
      end
   end

   task automatic send_record(input logic [31:0] word);
      while (!quiet && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_record(word);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input reg_addr_type addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {addr, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (addr)
         REG_EMIT_OVERFLOWS: cfg.emit_overflows = value[0];
         REG_EMIT_MARKERS:   cfg.emit_markers   = value[0];
         REG_EMIT_EARLY:     cfg.emit_early     = value[0];
         REG_PHOTON_LIMIT:   cfg.photon_limit   = value[16:0];
         REG_GATE_MIN:       cfg.gate_min       = value[15:0];
         REG_GATE_MAX:       cfg.gate_max       = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      write_reg(REG_EMIT_OVERFLOWS, 32'(c.emit_overflows));
      write_reg(REG_EMIT_MARKERS, 32'(c.emit_markers));
      write_reg(REG_EMIT_EARLY, 32'(c.emit_early));
      write_reg(REG_PHOTON_LIMIT, {{15{c.photon_limit[16]}}, c.photon_limit});
      write_reg(REG_GATE_MIN, {{16{c.gate_min[15]}}, c.gate_min});
      write_reg(REG_GATE_MAX, {{16{c.gate_max[15]}}, c.gate_max});
   endtask

   function automatic logic [31:0] photon(input logic [5:0] ch, input logic [14:0] dly,
                                          input logic [9:0] nsync);
      return {1'b0, ch, dly, nsync};
   endfunction

   function automatic logic [31:0] special(input logic [5:0] ch, input logic [9:0] nsync);
      return {1'b1, ch, 15'($urandom), nsync};
   endfunction

   function automatic logic [15:0] pick_bound(input logic [15:0] extreme);
      case ($urandom_range(3))
         0: return {1'b1, 15'($urandom)};
         1: return 16'($urandom_range(200));
         2: return 16'($urandom_range(32767));
         default: return extreme;
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.emit_overflows = 1'($urandom_range(1));
      c.emit_markers   = ($urandom_range(3) != 0);
      c.emit_early     = 1'($urandom_range(1));
      case ($urandom_range(4))
         0: c.photon_limit = 17'h1FFFF;
         1: c.photon_limit = {1'b1, 16'($urandom)};
         2: c.photon_limit = 17'($urandom_range(8));
         3: c.photon_limit = 17'd65535;
         default: c.photon_limit = 17'($urandom_range(65535));
      endcase
      c.gate_min = pick_bound(16'd0);
      c.gate_max = pick_bound(16'd32767);
      return c;
   endfunction

   function automatic logic [31:0] random_record();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 55)
         return photon(6'($urandom), $urandom_range(1) ? 15'($urandom) : 15'($urandom_range(255)),
                       10'($urandom));
      else if (pick < 75)
         return special(6'($urandom_range(1, 15)), 10'($urandom));
      else if (pick < 85)
         return special(OVF_CHANNEL, $urandom_range(3) == 0 ? 10'd0 : 10'($urandom));
      else if (pick < 92)
         return special($urandom_range(1) ? 6'd0 : 6'($urandom_range(16, 62)), 10'($urandom));
      else
         return $urandom;
   endfunction

   task automatic test_early_photons();
      send_record(photon(6'd3, 15'd100, 10'd7));
      drain();
      write_reg(REG_EMIT_EARLY, 32'd1);
      write_reg(REG_EMIT_MARKERS, 32'd0);
      write_reg(REG_PHOTON_LIMIT, 32'd2);
      write_reg(REG_GATE_MIN, 32'd10);
      write_reg(REG_GATE_MAX, 32'd20);
      send_record(photon(6'd1, 15'd9, 10'd1));
      send_record(photon(6'd1, 15'd10, 10'd2));
      send_record(photon(6'd1, 15'd20, 10'd3));
      send_record(photon(6'd1, 15'd21, 10'd4));
      send_record(photon(6'd1, 15'd15, 10'd5));
      send_record(special(6'd2, 10'd500));
      drain();
      write_reg(REG_PHOTON_LIMIT, 32'd0);
      write_reg(REG_GATE_MIN, 32'd32767);
      write_reg(REG_GATE_MAX, 32'd32767);
      send_record(photon(6'd1, 15'd32767, 10'd0));
      send_record(photon(6'd1, 15'd32766, 10'd9));
      drain();
      write_reg(REG_EMIT_EARLY, 32'd0);
      write_reg(REG_EMIT_MARKERS, 32'd1);
      write_reg(REG_PHOTON_LIMIT, 32'hFFFF_FFFF);
      write_reg(REG_GATE_MIN, 32'hFFFF_FFFF);
      write_reg(REG_GATE_MAX, 32'hFFFF_FFFF);
   endtask

   task automatic test_markers();
      send_record(photon(6'd63, 15'd32767, 10'd1023));
      send_record(special(6'd0, 10'd5));
      send_record(special(6'd16, 10'd9));
      send_record(special(6'd62, 10'd1023));
      // marker at time zero leaves the channel unseen
      send_record(special(6'd1, 10'd0));
      send_record(special(6'd1, 10'd3));
      send_record(special(6'd1, 10'd8));
      send_record(special(6'd1, 10'd14));
      send_record(special(6'd1, 10'd2));
      send_record(photon(6'd0, 15'd0, 10'd0));
      send_record(special(OVF_CHANNEL, 10'd0));
      send_record(special(6'd15, 10'd1023));
      send_record(photon(6'd63, 15'd32767, 10'd1023));
      drain();
   endtask

   task automatic test_overflows();
      write_reg(REG_EMIT_OVERFLOWS, 32'd1);
      send_record(special(OVF_CHANNEL, 10'd0));
      send_record(special(OVF_CHANNEL, 10'd1023));
      send_record(photon(6'd5, 15'd42, 10'd1023));
      drain();
   endtask

   task automatic test_counter_saturation();
      quiet = 1'b1;
      send_record(special(OVF_CHANNEL, 10'd1));
      send_record(special(6'd4, 10'd10));
      repeat (20) send_record(photon(6'($urandom), 15'($urandom_range(7)), 10'($urandom)));
      drain();
      write_reg(REG_PHOTON_LIMIT, 32'd65535);
      send_record(photon(6'd2, 15'd1, 10'd1));
      send_record(photon(6'd2, 15'd2, 10'd2));
      send_record(special(OVF_CHANNEL, 10'd1));
      send_record(special(6'd4, 10'd20));
      send_record(photon(6'd2, 15'd3, 10'd3));
      drain();
      quiet = 1'b0;
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_settings({1'b1, 1'b1, 1'b1, 17'd65535, 16'd0, 16'd32767});
            1: apply_settings({1'b0, 1'b1, 1'b0, 17'h1FFFF, 16'hFFFF, 16'hFFFF});
            default: apply_settings(random_settings());
         endcase
         quiet = (phase == 5);
         repeat (125) send_record(random_record());
         drain();
      end
      quiet = 1'b0;
   endtask

   task automatic test_backpressure();
      apply_settings({1'b1, 1'b1, 1'b1, 17'h1FFFF, 16'hFFFF, 16'hFFFF});
      quiet = 1'b1;
      hold_len = 200;
      repeat (80) send_record(random_record());
      drain();
      quiet = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_early_photons();
      test_markers();
      test_overflows();
      test_counter_saturation();
      test_random_traffic();
      test_backpressure();
      drain();
      if (mismatches == 0 && reports_due.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
